[hw/rtl/sldc_pkg.sv]
// ----------------------------------------------------------------------------
// sldc_pkg
// Shared types and constants of the slew limited drive command core.
// ----------------------------------------------------------------------------
package sldc_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned LIMIT_W = 31;
   localparam int unsigned CSR_IDX_W = 3;
   // Q16.16 x Q16.16 product shifted down by the fraction width
   localparam int unsigned FRAC_W = 16;
   localparam int unsigned PROD_W = 2 * DATA_W - FRAC_W;

   typedef enum logic [1:0] {
      OP_TARGET = 2'd0,
      OP_TICK   = 2'd1,
      OP_MUX    = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED_GAIN   = 3'd0,
      CSR_SPEED_OFFSET = 3'd1,
      CSR_STEER_GAIN   = 3'd2,
      CSR_STEER_OFFSET = 3'd3,
      CSR_SERVO_LIMIT  = 3'd4,
      CSR_MOTOR_LIMIT  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] speed_gain;
      logic signed [DATA_W-1:0] speed_offset;
      logic signed [DATA_W-1:0] steer_gain;
      logic signed [DATA_W-1:0] steer_offset;
      logic [LIMIT_W-1:0]       servo_step_limit;
      logic [LIMIT_W-1:0]       motor_step_limit;
   } cfg_type;

   // steer offset write also presets the servo target and last servo value
   typedef struct packed {
      logic                     load;
      logic signed [DATA_W-1:0] value;
   } preset_type;

   // product stage handed from the scaling unit to the state update
   typedef struct packed {
      logic                     valid;
      logic [1:0]               operation;
      logic                     brake_active;
      logic signed [PROD_W-1:0] speed_prod;
      logic signed [PROD_W-1:0] steer_prod;
   } stage_type;

endpackage

[hw/rtl/sldc_if.sv]
// ----------------------------------------------------------------------------
// sldc channel interfaces
// Valid/ready channels for drive requests, command results and CSR writes.
// ----------------------------------------------------------------------------
interface sldc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [31:0] target_speed;
   logic signed [31:0] target_steer;
   logic               brake_active;

   modport source (output valid, operation, target_speed, target_steer, brake_active,
                   input ready);
   modport sink   (input valid, operation, target_speed, target_steer, brake_active,
                   output ready);
endinterface

interface sldc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] motor_command;
   logic signed [31:0] servo_command;
   logic               servo_present;

   modport source (output valid, motor_command, servo_command, servo_present,
                   input ready);
   modport sink   (input valid, motor_command, servo_command, servo_present,
                   output ready);
endinterface

interface sldc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/slew_limited_drive_command_core.sv]
// ----------------------------------------------------------------------------
// slew_limited_drive_command_core
// Scales drive targets into motor and servo targets and slews the commands.
// ----------------------------------------------------------------------------
// Channels: req_bus takes drive transactions (new target, tick, mux update
// with brake flag); rsp_bus returns one command transaction per tick and per
// active brake; csr_bus writes the six configuration registers and is always
// ready. Write configuration only while no transaction is in flight.
// A request passes the input register, the product register and the result
// register before its result appears on rsp_bus. Throughput: one transaction
// per cycle unless rsp_bus stalls; the path is set by the two 32x32 gain
// multipliers in the first stage and the clamp-add in the second.
// A new target is visible to a tick that follows it directly.
// Reset clears the configuration, both targets, both last values, the
// product stage and every valid flag; the block accepts requests in the
// first cycle after reset.
// When rsp_bus stalls, the held result stays and the two stages behind it
// keep filling; req_bus.ready drops once both are occupied by work that
// must wait for the result register.
// ----------------------------------------------------------------------------
module slew_limited_drive_command_core (
   input  logic       clock,
   input  logic       reset,
   sldc_req_if.sink   req_bus,
   sldc_rsp_if.source rsp_bus,
   sldc_csr_if.sink   csr_bus
);
   import sldc_pkg::*;

   cfg_type    cfg;
   preset_type preset;
   stage_type  stage;
   logic       take;

   sldc_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg),
      .preset  (preset)
   );

   sldc_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .cfg     (cfg),
      .take    (take),
      .stage   (stage)
   );

   sldc_update u_update (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .preset  (preset),
      .stage   (stage),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

endmodule

[hw/rtl/sldc_cfg.sv]
// ----------------------------------------------------------------------------
// sldc_cfg
// Configuration register file; a steer offset write raises a servo preset.
// ----------------------------------------------------------------------------
module sldc_cfg (
   input  logic                clock,
   input  logic                reset,
   sldc_csr_if.sink            csr_bus,
   output sldc_pkg::cfg_type   cfg,
   output sldc_pkg::preset_type preset
);
   import sldc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign csr_bus.ready = 1'b1;
   assign wr = csr_bus.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_SPEED_GAIN:   cfg_in.speed_gain       = csr_bus.data;
            CSR_SPEED_OFFSET: cfg_in.speed_offset     = csr_bus.data;
            CSR_STEER_GAIN:   cfg_in.steer_gain       = csr_bus.data;
            CSR_STEER_OFFSET: cfg_in.steer_offset     = csr_bus.data;
            CSR_SERVO_LIMIT:  cfg_in.servo_step_limit = csr_bus.data[LIMIT_W-1:0];
            CSR_MOTOR_LIMIT:  cfg_in.motor_step_limit = csr_bus.data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg          = cfg_ff;
   assign preset.load  = wr && (csr_index_type'(csr_bus.index) == CSR_STEER_OFFSET);
   assign preset.value = csr_bus.data;

endmodule

[hw/rtl/sldc_scale.sv]
// ----------------------------------------------------------------------------
// sldc_scale
// Input register and gain multipliers; products are registered for update.
// ----------------------------------------------------------------------------
module sldc_scale (
   input  logic                clock,
   input  logic                reset,
   sldc_req_if.sink            req_bus,
   input  sldc_pkg::cfg_type   cfg,
   input  logic                take,
   output sldc_pkg::stage_type stage
);
   import sldc_pkg::*;

   logic                     a_valid_ff;
   logic [1:0]               a_op_ff;
   logic signed [DATA_W-1:0] a_speed_ff;
   logic signed [DATA_W-1:0] a_steer_ff;
   logic                     a_brake_ff;

   stage_type                b_ff, b_in;
   logic                     b_free, a_free;
   logic signed [2*DATA_W-1:0] speed_full, steer_full;

   assign b_free        = !b_ff.valid || take;
   assign a_free        = !a_valid_ff || b_free;
   assign req_bus.ready = a_free;

   // floor of the Q32.32 product to Q32.16 is an arithmetic drop of the fraction
   assign speed_full = cfg.speed_gain * a_speed_ff;
   assign steer_full = cfg.steer_gain * a_steer_ff;

   always_comb begin
      b_in = b_ff;
      if (b_free) begin
         b_in.valid        = a_valid_ff;
         b_in.operation    = a_op_ff;
         b_in.brake_active = a_brake_ff;
         b_in.speed_prod   = speed_full[2*DATA_W-1:FRAC_W];
         b_in.steer_prod   = steer_full[2*DATA_W-1:FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_ff       <= '0;
      end else begin
         if (a_free) begin
            a_valid_ff <= req_bus.valid;
         end
         b_ff <= b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_free && req_bus.valid) begin
         a_op_ff    <= req_bus.operation;
         a_speed_ff <= req_bus.target_speed;
         a_steer_ff <= req_bus.target_steer;
         a_brake_ff <= req_bus.brake_active;
      end
   end

   assign stage = b_ff;

endmodule

[hw/rtl/sldc_update.sv]
// ----------------------------------------------------------------------------
// sldc_update
// Target and last-value state, slew clamp and the result register.
// ----------------------------------------------------------------------------
module sldc_update (
   input  logic                 clock,
   input  logic                 reset,
   input  sldc_pkg::cfg_type    cfg,
   input  sldc_pkg::preset_type preset,
   input  sldc_pkg::stage_type  stage,
   output logic                 take,
   sldc_rsp_if.source           rsp_bus
);
   import sldc_pkg::*;

   localparam int unsigned SUM_W = PROD_W + 1;

   function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
         r = v[DATA_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] slew(input logic signed [DATA_W-1:0] last,
                                                    input logic signed [DATA_W-1:0] target,
                                                    input logic [LIMIT_W-1:0] limit);
      logic signed [DATA_W:0] d;
      logic signed [DATA_W:0] lim;
      d   = {target[DATA_W-1], target} - {last[DATA_W-1], last};
      lim = {{(DATA_W+1-LIMIT_W){1'b0}}, limit};
      if (d > lim) begin
         d = lim;
      end else if (d < -lim) begin
         d = -lim;
      end
      return last + d[DATA_W-1:0];
   endfunction

   logic signed [DATA_W-1:0] speed_target_ff, speed_target_in;
   logic signed [DATA_W-1:0] servo_target_ff, servo_target_in;
   logic signed [DATA_W-1:0] last_servo_ff, last_servo_in;
   logic signed [DATA_W-1:0] last_motor_ff, last_motor_in;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] motor_cmd_ff, motor_cmd_in;
   logic signed [DATA_W-1:0] servo_cmd_ff, servo_cmd_in;
   logic                     servo_present_ff, servo_present_in;

   logic                     is_tick, is_brake, is_target, has_result, out_ready, go;
   logic signed [SUM_W-1:0]  speed_sum, steer_sum;
   logic signed [DATA_W-1:0] servo_next, motor_next;

   assign is_target  = stage.operation == OP_TARGET;
   assign is_tick    = stage.operation == OP_TICK;
   assign is_brake   = (stage.operation == OP_MUX) && stage.brake_active;
   assign has_result = is_tick || is_brake;

   assign out_ready = !rsp_valid_ff || rsp_bus.ready;
   assign take      = !has_result || out_ready;
   assign go        = stage.valid && take;

   assign speed_sum = {stage.speed_prod[PROD_W-1], stage.speed_prod}
                      - SUM_W'(cfg.speed_offset);
   assign steer_sum = {stage.steer_prod[PROD_W-1], stage.steer_prod}
                      + SUM_W'(cfg.steer_offset);

   assign servo_next = slew(last_servo_ff, servo_target_ff, cfg.servo_step_limit);
   assign motor_next = slew(last_motor_ff, speed_target_ff, cfg.motor_step_limit);

   always_comb begin
      speed_target_in = speed_target_ff;
      servo_target_in = servo_target_ff;
      last_servo_in   = last_servo_ff;
      last_motor_in   = last_motor_ff;
      if (go) begin
         if (is_target) begin
            speed_target_in = sat_sum(speed_sum);
            servo_target_in = sat_sum(steer_sum);
         end else if (is_tick) begin
            last_servo_in = servo_next;
            last_motor_in = motor_next;
         end else if (is_brake) begin
            speed_target_in = '0;
         end
      end
      if (preset.load) begin
         servo_target_in = preset.value;
         last_servo_in   = preset.value;
      end
   end

   // brake transaction carries zero commands and no servo
   always_comb begin
      motor_cmd_in     = motor_cmd_ff;
      servo_cmd_in     = servo_cmd_ff;
      servo_present_in = servo_present_ff;
      if (go && has_result) begin
         motor_cmd_in     = is_tick ? motor_next : '0;
         servo_cmd_in     = is_tick ? servo_next : '0;
         servo_present_in = is_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_target_ff <= '0;
         servo_target_ff <= '0;
         last_servo_ff   <= '0;
         last_motor_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         speed_target_ff <= speed_target_in;
         servo_target_ff <= servo_target_in;
         last_servo_ff   <= last_servo_in;
         last_motor_ff   <= last_motor_in;
         if (out_ready) begin
            rsp_valid_ff <= go && has_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      motor_cmd_ff     <= motor_cmd_in;
      servo_cmd_ff     <= servo_cmd_in;
      servo_present_ff <= servo_present_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.motor_command = motor_cmd_ff;
   assign rsp_bus.servo_command = servo_cmd_ff;
   assign rsp_bus.servo_present = servo_present_ff;

endmodule

[hw/rtl/sldc_checker.sv]
// ----------------------------------------------------------------------------
// sldc_checker
// Port-level checks of the drive command core, bound to the top level.
// ----------------------------------------------------------------------------
module sldc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] motor_command,
   input logic [31:0] servo_command,
   input logic        servo_present,
   input logic        csr_valid,
   input logic        csr_ready
);

   // hold a stalled transaction unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(motor_command)
                                 && $stable(servo_command) && $stable(servo_present))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // brake transactions carry zero commands
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !servo_present |-> motor_command == 32'd0 && servo_command == 32'd0)
      else $error("brake result not zero");

   assert property (@(posedge clock) disable iff (reset) csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind slew_limited_drive_command_core sldc_checker u_sldc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .motor_command (rsp_bus.motor_command),
   .servo_command (rsp_bus.servo_command),
   .servo_present (rsp_bus.servo_present),
   .csr_valid     (csr_bus.valid),
   .csr_ready     (csr_bus.ready)
);
